@@ hw/rtl/weighted_group_accumulator_assert.svh @@
// Assertion macros for the weighted group accumulator.
// WGA_ASSERT_SAME checks a consequent in the same cycle as its antecedent.
// WGA_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef WEIGHTED_GROUP_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_GROUP_ACCUMULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WGA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define WGA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WGA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define WGA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hw/rtl/wga_pkg.sv @@
`default_nettype none
package wga_pkg;

  localparam int GROUPS_DEF = 64;
  localparam int DIM_DEF    = 64;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 64;
  localparam int FRAC_SHIFT = 24;

  localparam logic [6:0] NUM_GROUPS_RST = 7'd64;

  // Byte address of the only configuration register.
  localparam logic [1:0] ADDR_NUM_GROUPS = 2'd0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CLR_SWEEP = 1'b0,
    CLR_RUN   = 1'b1
  } clr_state_t;

  // One word of the accumulator memory: sticky saturation mark and the sum.
  typedef struct packed {
    logic                    sat;
    logic signed [ACC_W-1:0] sum;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/wga_acc_mem.sv @@
`default_nettype none
module wga_acc_mem #(
  parameter int DEPTH = wga_pkg::GROUPS_DEF * wga_pkg::DIM_DEF,
  parameter int AW    = 12,
  parameter int W     = $bits(wga_pkg::entry_t)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of an address written at the same edge returns the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/wga_update.sv @@
`default_nettype none
module wga_update (
  input  wire logic                              is_read,
  input  wire wga_pkg::entry_t                   cur,
  input  wire logic signed [wga_pkg::PROD_W-1:0] prod,
  output wga_pkg::entry_t                        nxt
);

  logic signed [wga_pkg::ACC_W:0] acc_x;
  logic signed [wga_pkg::ACC_W:0] inc_x;
  logic        [wga_pkg::ACC_W:0] rnd_x;
  logic        [wga_pkg::ACC_W:0] sum_x;

  // Round half up: floor((p + 2^23) / 2^24) equals (p >>> 24) plus bit 23 of p.
  assign acc_x = (wga_pkg::ACC_W + 1)'(cur.sum);
  assign inc_x = (wga_pkg::ACC_W + 1)'($signed(prod[wga_pkg::PROD_W-1:wga_pkg::FRAC_SHIFT]));
  assign rnd_x = (wga_pkg::ACC_W + 1)'(prod[wga_pkg::FRAC_SHIFT-1]);
  assign sum_x = acc_x + inc_x + rnd_x;

  always_comb begin
    nxt = '0;
    if (!is_read) begin
      if (sum_x[wga_pkg::ACC_W] != sum_x[wga_pkg::ACC_W-1]) begin
        nxt.sat = 1'b1;
        nxt.sum = sum_x[wga_pkg::ACC_W] ? wga_pkg::ACC_MIN : wga_pkg::ACC_MAX;
      end else begin
        nxt.sat = cur.sat;
        nxt.sum = sum_x[wga_pkg::ACC_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/wga_clear.sv @@
`default_nettype none
module wga_clear #(
  parameter int SLOTS = wga_pkg::GROUPS_DEF * wga_pkg::DIM_DEF,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  output logic               busy,
  output logic      [AW-1:0] addr
);

  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  wga_pkg::clr_state_t state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wga_pkg::CLR_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wga_pkg::CLR_SWEEP: begin
        if (cnt_r == LAST) begin
          state_nxt = wga_pkg::CLR_RUN;
        end
      end
      wga_pkg::CLR_RUN: begin
        state_nxt = wga_pkg::CLR_RUN;
      end
      default: begin
        state_nxt = wga_pkg::CLR_SWEEP;
      end
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    cnt_nxt = cnt_r;
    unique case (state_r)
      wga_pkg::CLR_SWEEP: begin
        busy    = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
      end
      wga_pkg::CLR_RUN: begin
        busy = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign addr = cnt_r;

endmodule
`default_nettype wire

@@ hw/rtl/weighted_group_accumulator.sv @@
// Accumulate items are taken one per cycle unless the input is stalled; an executing read
// item stalls the input. A read result passes the execute registers and the result register.
// Throughput is set by the single read-modify-write port pair of the accumulator memory.
// After reset a sweep zeroes all GROUPS*DIM memory words (4096 by default);
// the input is stalled during the sweep, configuration writes are taken throughout.
`default_nettype none
module weighted_group_accumulator #(
  parameter int GROUPS = wga_pkg::GROUPS_DEF,
  parameter int DIM    = wga_pkg::DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic signed [15:0] in_group,
  input  wire logic        [5:0]  in_element,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic signed [31:0] in_factor,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_sum,
  output logic        [5:0]       out_read_group,
  output logic        [5:0]       out_read_element,
  output logic                    out_saturated,

  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic        [1:0]  cfg_paddr,
  input  wire logic        [31:0] cfg_pwdata,
  output logic             [31:0] cfg_prdata,
  output logic                    cfg_pready
);

`include "weighted_group_accumulator_assert.svh"

  localparam int SLOTS = GROUPS * DIM;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW    = $bits(wga_pkg::entry_t);

  // Configuration.
  logic [6:0] num_groups_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(num_groups_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_groups_r <= wga_pkg::NUM_GROUPS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == wga_pkg::ADDR_NUM_GROUPS) begin
      num_groups_r <= cfg_pwdata[6:0];
    end
  end

  // Clearing sweep.
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  wga_clear #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .addr  (clr_addr)
  );

  // Pipeline registers between accept and execute.
  logic                                p_valid_r;
  logic                                p_read_r;
  logic                                p_hit_r;
  logic [AW-1:0]                       p_addr_r;
  logic [5:0]                          p_group_r;
  logic [5:0]                          p_elem_r;
  logic signed [wga_pkg::PROD_W-1:0]   p_prod_r;

  // Last write of an executed item, forwarded when the memory read was too early.
  logic                                lw_valid_r;
  logic [AW-1:0]                       lw_addr_r;
  wga_pkg::entry_t                     lw_data_r;

  logic                                out_valid_r;

  logic                                in_accept;
  logic                                in_is_read;
  logic                                grp_in_dim;
  logic                                grp_below_cfg;
  logic                                in_hit;
  logic [AW-1:0]                       in_addr;
  logic signed [wga_pkg::PROD_W-1:0]   in_prod;

  logic [EW-1:0]                       mem_q;
  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr;
  logic [EW-1:0]                       mem_wdata;

  wga_pkg::entry_t                     cur;
  wga_pkg::entry_t                     upd;
  logic                                exec_wr;
  logic                                out_load;

  // A read item waits for the output register to be free, so it never overwrites a result.
  assign in_stall  = clr_busy || (p_valid_r && p_read_r) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign in_is_read    = (in_opcode == wga_pkg::OP_READ);
  assign grp_in_dim    = !in_group[15] && (in_group[14:0] < 15'(GROUPS)) &&
                         (16'(in_element) < 16'(DIM));
  assign grp_below_cfg = (in_group[14:0] < 15'(num_groups_r));
  assign in_hit        = grp_in_dim && (in_is_read || grp_below_cfg);
  assign in_addr       = AW'(32'(in_group[14:0]) * 32'(DIM) + 32'(in_element));
  assign in_prod       = in_element_value * in_factor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_read_r  <= in_is_read;
      p_hit_r   <= in_hit;
      p_addr_r  <= in_addr;
      p_group_r <= in_group[5:0];
      p_elem_r  <= in_element;
      p_prod_r  <= in_prod;
    end
  end

  wga_acc_mem #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .W     (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (mem_q)
  );

  assign cur = (lw_valid_r && lw_addr_r == p_addr_r) ? lw_data_r : wga_pkg::entry_t'(mem_q);

  wga_update u_update (
    .is_read (p_read_r),
    .cur     (cur),
    .prod    (p_prod_r),
    .nxt     (upd)
  );

  assign exec_wr   = p_valid_r && p_hit_r;
  assign mem_we    = clr_busy || exec_wr;
  assign mem_waddr = clr_busy ? clr_addr : p_addr_r;
  assign mem_wdata = clr_busy ? '0 : EW'(upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (clr_busy) begin
      lw_valid_r <= 1'b0;
    end else if (exec_wr) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_wr) begin
      lw_addr_r <= p_addr_r;
      lw_data_r <= upd;
    end
  end

  // Result register.
  assign out_load = p_valid_r && p_read_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum          <= p_hit_r ? cur.sum : '0;
      out_saturated    <= p_hit_r ? cur.sat : 1'b0;
      out_read_group   <= p_group_r;
      out_read_element <= p_elem_r;
    end
  end

  assign out_valid = out_valid_r;

  `WGA_ASSERT_SAME(a_read_finds_free_output, clk, rst_n, p_valid_r && p_read_r, !out_valid_r, "read executes while the result register is occupied")
  `WGA_ASSERT_NEXT(a_read_gives_result, clk, rst_n, p_valid_r && p_read_r, out_valid_r, "read item produced no result")
  `WGA_ASSERT_SAME(a_no_exec_in_sweep, clk, rst_n, p_valid_r, !clr_busy, "item executes during the clearing sweep")
  `WGA_ASSERT_SAME(a_no_forward_in_sweep, clk, rst_n, lw_valid_r, !clr_busy, "forwarding entry live during the clearing sweep")

endmodule
`default_nettype wire

@@ verif/wga_checker.sv @@
`timescale 1ns / 100ps
module wga_checker (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_opcode,
  input  logic signed [15:0] in_group,
  input  logic        [5:0]  in_element,
  input  logic signed [31:0] in_element_value,
  input  logic signed [31:0] in_factor,

  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [47:0] out_sum,
  input  logic        [5:0]  out_read_group,
  input  logic        [5:0]  out_read_element,
  input  logic               out_saturated,

  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic        [1:0]  cfg_paddr,
  input  logic        [31:0] cfg_pwdata,
  input  logic               cfg_pready,

  output int                 mismatch_count,
  output int                 results_pending
);

  localparam int SLOTS = wga_pkg::GROUPS_DEF * wga_pkg::DIM_DEF;

  typedef struct packed {
    logic signed [wga_pkg::ACC_W-1:0] sum;
    logic        [5:0]                grp;
    logic        [5:0]                elem;
    logic                             sat;
  } read_result_t;

  logic signed [wga_pkg::ACC_W-1:0] acc_model [SLOTS];
  logic                             sat_model [SLOTS];
  logic        [6:0]                group_limit;
  read_result_t                     read_results_due [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic note_mismatch(input string field, input longint want, input longint got);
    $display("%0t: read result %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Accumulate beats update the model store; read beats queue the expected result and clear the slot.
  task automatic model_accumulator_op(input logic opc, input logic signed [15:0] g,
                                      input logic [5:0] e, input logic signed [31:0] v,
                                      input logic signed [31:0] f);
    int           lim;
    int           slot;
    longint       prod;
    longint       inc;
    longint       total;
    read_result_t res;
    lim = (int'(group_limit) < wga_pkg::GROUPS_DEF) ? int'(group_limit)
                                                     : wga_pkg::GROUPS_DEF;
    if (wga_pkg::op_t'(opc) == wga_pkg::OP_ACCUM) begin
      if (g >= 0 && int'(g) < lim && int'(e) < wga_pkg::DIM_DEF) begin
        slot  = int'(g) * wga_pkg::DIM_DEF + int'(e);
        prod  = longint'(v) * longint'(f);
        // Round half up: add half an LSB, then an arithmetic shift floors.
        inc   = (prod + (longint'(1) << 23)) >>> wga_pkg::FRAC_SHIFT;
        total = longint'(acc_model[slot]) + inc;
        if (total > longint'(wga_pkg::ACC_MAX)) begin
          total           = longint'(wga_pkg::ACC_MAX);
          sat_model[slot] = 1'b1;
        end else if (total < longint'(wga_pkg::ACC_MIN)) begin
          total           = longint'(wga_pkg::ACC_MIN);
          sat_model[slot] = 1'b1;
        end
        acc_model[slot] = total[wga_pkg::ACC_W-1:0];
      end
    end else begin
      res.sum  = '0;
      res.grp  = g[5:0];
      res.elem = e;
      res.sat  = 1'b0;
      if (g >= 0 && int'(g) < wga_pkg::GROUPS_DEF && int'(e) < wga_pkg::DIM_DEF) begin
        slot            = int'(g) * wga_pkg::DIM_DEF + int'(e);
        res.sum         = acc_model[slot];
        res.sat         = sat_model[slot];
        acc_model[slot] = '0;
        sat_model[slot] = 1'b0;
      end
      read_results_due.push_back(res);
    end
  endtask

  task automatic check_read_result();
    read_result_t want;
    if (read_results_due.size() == 0) begin
      $display("%0t: unexpected read result: sum %0d group %0d element %0d saturated %b",
               $time, out_sum, out_read_group, out_read_element, out_saturated);
      mismatch_count++;
    end else begin
      want = read_results_due.pop_front();
      if (want.sum !== out_sum)
        note_mismatch("sum", $signed(want.sum), $signed(out_sum));
      if (want.grp !== out_read_group)
        note_mismatch("group", want.grp, out_read_group);
      if (want.elem !== out_read_element)
        note_mismatch("element", want.elem, out_read_element);
      if (want.sat !== out_saturated)
        note_mismatch("saturated", want.sat, out_saturated);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        acc_model[i] = '0;
        sat_model[i] = 1'b0;
      end
      group_limit = wga_pkg::NUM_GROUPS_RST;
      read_results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == wga_pkg::ADDR_NUM_GROUPS)
        group_limit = cfg_pwdata[6:0];
      if (in_valid && !in_stall)
        model_accumulator_op(in_opcode, in_group, in_element, in_element_value, in_factor);
      if (out_valid && !out_stall)
        check_read_result();
    end
    results_pending = read_results_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    GAPS_NONE,
    GAPS_SENDER,
    GAPS_RECEIVER,
    GAPS_BOTH
  } gap_mode_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_opcode;
  logic signed [15:0] in_group;
  logic        [5:0]  in_element;
  logic signed [31:0] in_element_value;
  logic signed [31:0] in_factor;
  logic               out_valid;
  logic               out_stall;
  logic signed [47:0] out_sum;
  logic        [5:0]  out_read_group;
  logic        [5:0]  out_read_element;
  logic               out_saturated;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic        [1:0]  cfg_paddr;
  logic        [31:0] cfg_pwdata;
  logic        [31:0] cfg_prdata;
  logic               cfg_pready;

  int   mismatch_count;
  int   results_pending;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   group_setting;
  int   hold_left;
  logic hold_kick;
  logic hold_seen;

  weighted_group_accumulator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_group         (in_group),
    .in_element       (in_element),
    .in_element_value (in_element_value),
    .in_factor        (in_factor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sum          (out_sum),
    .out_read_group   (out_read_group),
    .out_read_element (out_read_element),
    .out_saturated    (out_saturated),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  wga_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_group         (in_group),
    .in_element       (in_element),
    .in_element_value (in_element_value),
    .in_factor        (in_factor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sum          (out_sum),
    .out_read_group   (out_read_group),
    .out_read_element (out_read_element),
    .out_saturated    (out_saturated),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_pready       (cfg_pready),
    .mismatch_count   (mismatch_count),
    .results_pending  (results_pending)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, plus a long hold-off whenever the stimulus toggles hold_kick.
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  task automatic set_gaps(input gap_mode_t mode);
    unique case (mode)
      GAPS_NONE: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end
      GAPS_SENDER: begin
        tx_idle_pct = 61;
        rx_stall_pct <= 0;
      end
      GAPS_RECEIVER: begin
        tx_idle_pct = 0;
        rx_stall_pct <= 61;
      end
      default: begin
        tx_idle_pct = 11;
        rx_stall_pct <= 11;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send(input wga_pkg::op_t op, input logic signed [15:0] g,
                      input logic [5:0] e, input logic [31:0] v, input logic [31:0] f);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_group         <= g;
    in_element       <= e;
    in_element_value <= v;
    in_factor        <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering beats and wait until every read has returned, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_num_groups(input logic [6:0] value);
    logic [31:0] upper;
    upper       = $urandom;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= wga_pkg::ADDR_NUM_GROUPS;
    cfg_pwdata  <= {upper[24:0], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    group_setting = value;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0080_0000;
      5:       return 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_group();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 3));
    if (r < 55) return 16'($urandom_range(60, 63));
    if (r < 70) return 16'($urandom_range(0, 63));
    // Just around the configured limit, where skipping starts.
    if (r < 80) return 16'(group_setting + int'($urandom_range(0, 2)) - 1);
    if (r < 88) return 16'($urandom_range(64, 130));
    return 16'($urandom);
  endfunction

  function automatic logic [5:0] pick_element();
    if ($urandom_range(0, 99) < 60) return 6'($urandom_range(0, 3));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_noise();
    logic signed [15:0] g;
    logic [31:0]        r;
    r = $urandom;
    g = r[0] ? pick_group() : 16'($urandom);
    send(r[1] ? wga_pkg::OP_READ : wga_pkg::OP_ACCUM, g, 6'($urandom),
         pick_value(), pick_value());
  endtask

  // Runs of accumulates into one slot, usually closed by a read of it, with noise mixed in.
  task automatic run_mix(input int n_items);
    int                 sent;
    int                 k;
    logic signed [15:0] g;
    logic [5:0]         e;
    sent = 0;
    while (sent < n_items) begin
      g = pick_group();
      e = pick_element();
      k = $urandom_range(1, 6);
      repeat (k) begin
        if ($urandom_range(0, 99) < 20) begin
          send_noise();
          sent++;
        end
        send(wga_pkg::OP_ACCUM, g, e, pick_value(), pick_value());
        sent++;
      end
      if ($urandom_range(0, 99) < 85) begin
        send(wga_pkg::OP_READ, g, e, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    logic [6:0]  settings [8];
    logic [31:0] clamp_factor;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = 1'b0;
    in_group         = '0;
    in_element       = '0;
    in_element_value = '0;
    in_factor        = '0;
    out_stall        = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    hold_kick        = 1'b0;
    hold_seen        = 1'b0;
    hold_left        = 0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    group_setting    = wga_pkg::NUM_GROUPS_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: rounding corners, skipped groups, out-of-range reads.
    write_num_groups(7'd64);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd0, 32'h8000_0000, 32'h8000_0000);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd1, 32'h0000_0001, 32'h0080_0000);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd1, 32'hFFFF_FFFF, 32'h0080_0000);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd1, 32'hFFFF_FFFF, 32'h0080_0001);
    send(wga_pkg::OP_ACCUM, 16'sd63, 6'd63, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, -16'sd1, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, 16'sd64, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, 16'sh8000, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, 16'sh7FFF, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd2, 32'h0000_0000, 32'h7FFF_FFFF);
    send(wga_pkg::OP_READ, 16'sd0, 6'd0, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd0, 6'd1, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd63, 6'd63, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd0, 6'd2, $urandom, $urandom);
    send(wga_pkg::OP_READ, -16'sd1, 6'd5, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd64, 6'd0, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sh8000, 6'd63, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sh7FFF, 6'd0, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd0, 6'd0, $urandom, $urandom);
    drain();
    // With no groups enabled every accumulate is dropped.
    write_num_groups(7'd0);
    send(wga_pkg::OP_ACCUM, 16'sd1, 6'd1, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_READ, 16'sd1, 6'd1, $urandom, $urandom);
    drain();
    // A group past the limit still reads back normally.
    write_num_groups(7'd1);
    send(wga_pkg::OP_ACCUM, 16'sd1, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_ACCUM, 16'sd0, 6'd2, 32'h0100_0000, 32'h0100_0000);
    send(wga_pkg::OP_READ, 16'sd1, 6'd2, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd0, 6'd2, $urandom, $urandom);

    settings[0] = 7'd64;
    settings[1] = 7'd1;
    settings[2] = 7'd127;
    settings[3] = 7'd0;
    settings[4] = 7'($urandom_range(2, 63));
    settings[5] = 7'd64;
    settings[6] = 7'($urandom_range(65, 127));
    settings[7] = 7'd4;
    for (int p = 0; p < 8; p++) begin
      drain();
      write_num_groups(settings[p]);
      set_gaps(gap_mode_t'(p % 4));
      if (p == 2)
        hold_kick <= ~hold_kick;
      if (p == 5) begin
        run_mix(30);
        drain();
        run_mix(30);
      end else begin
        run_mix(60);
      end
    end

    // One slot driven into a clamp by maximum-magnitude products; the sign is random.
    drain();
    write_num_groups(7'd64);
    set_gaps(GAPS_BOTH);
    clamp_factor = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    repeat (520) begin
      send(wga_pkg::OP_ACCUM, 16'sd2, 6'd7, 32'h8000_0000, clamp_factor);
    end
    send(wga_pkg::OP_READ, 16'sd2, 6'd7, $urandom, $urandom);
    send(wga_pkg::OP_READ, 16'sd2, 6'd7, $urandom, $urandom);
    set_gaps(GAPS_NONE);
    run_mix(50);

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
